/* src/bcpa_pkg.sv */
package bcpa_pkg;

    localparam int unsigned DEG_MIN   = 2;
    localparam int unsigned DEG_MAX   = 63;
    localparam int unsigned GUARD_MAX = 200;

    localparam logic [63:0] INF_X = '1;

    typedef enum logic [1:0] {
        CFG_FIELD_DEGREE = 2'd0,
        CFG_MODULUS      = 2'd1,
        CFG_CURVE_A2     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        GF_MUL = 1'b0,
        GF_INV = 1'b1
    } gf_op_t;

    typedef struct packed {
        logic   start;
        gf_op_t op;
    } gf_cmd_t;

    // position of the highest set bit, zero for an all-zero word
    function automatic logic [5:0] top_bit(input logic [63:0] v);
        logic [5:0] d;
        d = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                d = 6'(i);
            end
        end
        return d;
    endfunction

endpackage

/* src/bcpa_if.sv */
interface bcpa_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] first_x;
    logic [62:0] first_y;
    logic [63:0] second_x;
    logic [62:0] second_y;
    logic [63:0] scalar;

    modport source (output valid, mode, first_x, first_y, second_x, second_y, scalar,
                    input ready);
    modport sink   (input valid, mode, first_x, first_y, second_x, second_y, scalar,
                    output ready);
endinterface

interface bcpa_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_x;
    logic [62:0] result_y;

    modport source (output valid, result_x, result_y, input ready);
    modport sink   (input valid, result_x, result_y, output ready);
endinterface

/* src/bcpa_gf.sv */
module bcpa_gf
    import bcpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gf_cmd_t     cmd,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] hi_mask,
    input  logic [63:0] modulus,
    output logic        done,
    output logic [63:0] res
);

    typedef enum logic [4:0] {
        G_IDLE = 5'b00001,
        G_MUL  = 5'b00010,
        G_CHK  = 5'b00100,
        G_STEP = 5'b01000,
        G_DONE = 5'b10000
    } gf_state_t;

    gf_state_t   state_reg, state_next;
    logic [63:0] u_reg, u_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] g1_reg, g1_next;
    logic [63:0] g2_reg, g2_next;
    logic [63:0] res_reg, res_next;
    logic [7:0]  guard_reg, guard_next;
    logic [5:0]  tu_reg, tu_next;
    logic [5:0]  tv_reg, tv_next;
    logic [63:0] u_sh;
    logic [5:0]  j;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        v_reg     <= v_next;
        g1_reg    <= g1_next;
        g2_reg    <= g2_next;
        res_reg   <= res_next;
        guard_reg <= guard_next;
        tu_reg    <= tu_next;
        tv_reg    <= tv_next;
    end

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        g1_next    = g1_reg;
        g2_next    = g2_reg;
        res_next   = res_reg;
        guard_next = guard_reg;
        tu_next    = tu_reg;
        tv_next    = tv_reg;
        u_sh       = {u_reg[62:0], 1'b0};
        j          = '0;

        unique case (state_reg)
            G_IDLE:
            begin
                if (cmd.start)
                begin
                    u_next = a;
                    if (cmd.op == GF_MUL)
                    begin
                        v_next     = b;
                        g1_next    = '0;
                        state_next = G_MUL;
                    end
                    else
                    begin
                        v_next     = modulus;
                        g1_next    = 64'd1;
                        g2_next    = '0;
                        guard_next = '0;
                        state_next = G_CHK;
                    end
                end
            end
            G_MUL:
            begin
                // shift-and-add, operand a in u, multiplier b in v
                if (v_reg == '0)
                begin
                    res_next   = g1_reg;
                    state_next = G_DONE;
                end
                else
                begin
                    if (v_reg[0])
                    begin
                        g1_next = g1_reg ^ u_reg;
                    end
                    v_next = {1'b0, v_reg[63:1]};
                    u_next = ((u_sh & hi_mask) != '0) ? (u_sh ^ modulus) : u_sh;
                end
            end
            G_CHK:
            begin
                if (u_reg == 64'd1)
                begin
                    res_next   = g1_reg;
                    state_next = G_DONE;
                end
                else if (u_reg == '0 || v_reg == '0 || guard_reg > 8'(GUARD_MAX))
                begin
                    res_next   = '0;
                    state_next = G_DONE;
                end
                else
                begin
                    guard_next = guard_reg + 8'd1;
                    tu_next    = top_bit(u_reg);
                    tv_next    = top_bit(v_reg);
                    state_next = G_STEP;
                end
            end
            G_STEP:
            begin
                if (tu_reg >= tv_reg)
                begin
                    j       = tu_reg - tv_reg;
                    u_next  = u_reg ^ (v_reg << j);
                    g1_next = g1_reg ^ (g2_reg << j);
                end
                else
                begin
                    j       = tv_reg - tu_reg;
                    u_next  = v_reg ^ (u_reg << j);
                    v_next  = u_reg;
                    g1_next = g2_reg ^ (g1_reg << j);
                    g2_next = g1_reg;
                end
                state_next = G_CHK;
            end
            G_DONE:
            begin
                state_next = G_IDLE;
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    assign done = (state_reg == G_DONE);
    assign res  = res_reg;

endmodule

/* src/binary_curve_point_arithmetic_top.sv */
// work: mode add does one point addition, mode mul up to 128 point additions
// (each at most one inversion and four multiplications, three for a non-doubling
// addition, on the shared field unit)
// transactions: one at a time, the next is taken once the result is held
// reset: asynchronous active-low, clears control state and restores the configuration registers
module binary_curve_point_arithmetic_top
    import bcpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    bcpa_in_if.sink     in_ch,
    bcpa_out_if.source  out_ch
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_INV  = 9'b000000100,
        S_M0   = 9'b000001000,
        S_M1   = 9'b000010000,
        S_M2   = 9'b000100000,
        S_M3   = 9'b001000000,
        S_NEXT = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  degree_reg;
    logic [63:0] modulus_reg;
    logic [62:0] a2_reg;

    logic        mode_reg, mode_next;
    logic [63:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [63:0] bx_reg, bx_next, by_reg, by_next;
    logic [63:0] px_reg, px_next, py_reg, py_next;
    logic [63:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [63:0] k_reg, k_next;
    logic [5:0]  idx_reg, idx_next;
    logic        dbl_step_reg, dbl_step_next;
    logic        dbl_reg, dbl_next;
    logic [63:0] lam_reg, lam_next;
    logic [63:0] x3_reg, x3_next;
    logic [63:0] tmp_reg, tmp_next;

    logic        gf_start_reg, gf_start_next;
    gf_op_t      gf_op_reg, gf_op_next;
    logic [63:0] gf_a_reg, gf_a_next;
    logic [63:0] gf_b_reg, gf_b_next;
    gf_cmd_t     gf_cmd;
    logic        gf_done;
    logic [63:0] gf_res;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_x_reg, out_x_next;
    logic [62:0] out_y_reg, out_y_next;

    logic [5:0]  degree_eff;
    logic [63:0] hi_mask;
    logic [63:0] lam_c;
    logic [63:0] x3_c;
    logic        advance;

    always_comb
    begin
        degree_eff = (degree_reg < 6'(DEG_MIN)) ? 6'(DEG_MIN) : degree_reg;
        hi_mask    = 64'd1 << degree_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg  <= 6'd2;
            modulus_reg <= 64'd7;
            a2_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIELD_DEGREE: degree_reg  <= cfg_data[5:0];
                CFG_MODULUS:      modulus_reg <= cfg_data;
                CFG_CURVE_A2:     a2_reg      <= cfg_data[62:0];
                default:          ;
            endcase
        end
    end

    assign gf_cmd = '{start: gf_start_reg, op: gf_op_reg};

    bcpa_gf u_gf (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (gf_cmd),
        .a       (gf_a_reg),
        .b       (gf_b_reg),
        .hi_mask (hi_mask),
        .modulus (modulus_reg),
        .done    (gf_done),
        .res     (gf_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gf_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gf_start_reg  <= gf_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        k_reg        <= k_next;
        idx_reg      <= idx_next;
        dbl_step_reg <= dbl_step_next;
        dbl_reg      <= dbl_next;
        lam_reg      <= lam_next;
        x3_reg       <= x3_next;
        tmp_reg      <= tmp_next;
        gf_op_reg    <= gf_op_next;
        gf_a_reg     <= gf_a_next;
        gf_b_reg     <= gf_b_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        dbl_step_next  = dbl_step_reg;
        dbl_next       = dbl_reg;
        lam_next       = lam_reg;
        x3_next        = x3_reg;
        tmp_next       = tmp_reg;
        gf_start_next  = 1'b0;
        gf_op_next     = gf_op_reg;
        gf_a_next      = gf_a_reg;
        gf_b_next      = gf_b_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        advance        = 1'b0;

        lam_c = gf_res ^ (dbl_reg ? ax_reg : 64'd0);
        x3_c  = gf_res ^ lam_reg ^ {1'b0, a2_reg} ^ (dbl_reg ? 64'd0 : (ax_reg ^ bx_reg));

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mode_next = in_ch.mode;
                    px_next   = in_ch.first_x;
                    py_next   = {1'b0, in_ch.first_y};
                    k_next    = in_ch.scalar;
                    if (in_ch.mode)
                    begin
                        rx_next       = INF_X;
                        ry_next       = '0;
                        ax_next       = INF_X;
                        ay_next       = '0;
                        bx_next       = INF_X;
                        by_next       = '0;
                        idx_next      = 6'd63;
                        dbl_step_next = 1'b1;
                    end
                    else
                    begin
                        ax_next = in_ch.first_x;
                        ay_next = {1'b0, in_ch.first_y};
                        bx_next = in_ch.second_x;
                        by_next = {1'b0, in_ch.second_y};
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (ax_reg == INF_X)
                begin
                    rx_next    = bx_reg;
                    ry_next    = by_reg;
                    state_next = S_NEXT;
                end
                else if (bx_reg == INF_X)
                begin
                    rx_next    = ax_reg;
                    ry_next    = ay_reg;
                    state_next = S_NEXT;
                end
                else if (ax_reg == bx_reg)
                begin
                    if (ay_reg != by_reg || ax_reg == '0)
                    begin
                        rx_next    = INF_X;
                        ry_next    = '0;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        dbl_next      = 1'b1;
                        gf_start_next = 1'b1;
                        gf_op_next    = GF_INV;
                        gf_a_next     = ax_reg;
                        state_next    = S_INV;
                    end
                end
                else
                begin
                    dbl_next      = 1'b0;
                    gf_start_next = 1'b1;
                    gf_op_next    = GF_INV;
                    gf_a_next     = ax_reg ^ bx_reg;
                    state_next    = S_INV;
                end
            end
            S_INV:
            begin
                if (gf_done)
                begin
                    gf_start_next = 1'b1;
                    gf_op_next    = GF_MUL;
                    gf_a_next     = dbl_reg ? ay_reg : (ay_reg ^ by_reg);
                    gf_b_next     = gf_res;
                    state_next    = S_M0;
                end
            end
            S_M0:
            begin
                if (gf_done)
                begin
                    lam_next      = lam_c;
                    gf_start_next = 1'b1;
                    gf_a_next     = lam_c;
                    gf_b_next     = lam_c;
                    state_next    = S_M1;
                end
            end
            S_M1:
            begin
                if (gf_done)
                begin
                    x3_next       = x3_c;
                    gf_start_next = 1'b1;
                    gf_a_next     = dbl_reg ? ax_reg : lam_reg;
                    gf_b_next     = dbl_reg ? ax_reg : (ax_reg ^ x3_c);
                    state_next    = S_M2;
                end
            end
            S_M2:
            begin
                if (gf_done)
                begin
                    if (dbl_reg)
                    begin
                        tmp_next      = gf_res;
                        gf_start_next = 1'b1;
                        gf_a_next     = lam_reg ^ 64'd1;
                        gf_b_next     = x3_reg;
                        state_next    = S_M3;
                    end
                    else
                    begin
                        rx_next    = x3_reg;
                        ry_next    = gf_res ^ x3_reg ^ ay_reg;
                        state_next = S_NEXT;
                    end
                end
            end
            S_M3:
            begin
                if (gf_done)
                begin
                    rx_next    = x3_reg;
                    ry_next    = tmp_reg ^ gf_res;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (!mode_reg)
                begin
                    state_next = S_FIN;
                end
                else if (dbl_step_reg && k_reg[idx_reg])
                begin
                    ax_next       = rx_reg;
                    ay_next       = ry_reg;
                    bx_next       = px_reg;
                    by_next       = py_reg;
                    dbl_step_next = 1'b0;
                    state_next    = S_LOAD;
                end
                else
                begin
                    advance = 1'b1;
                end
                if (advance)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next      = idx_reg - 6'd1;
                        ax_next       = rx_reg;
                        ay_next       = ry_reg;
                        bx_next       = rx_reg;
                        by_next       = ry_reg;
                        dbl_step_next = 1'b1;
                        state_next    = S_LOAD;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = rx_reg;
                    out_y_next     = (rx_reg == INF_X) ? 63'd0 : ry_reg[62:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.result_x = out_x_reg;
    assign out_ch.result_y = out_y_reg;

endmodule

/* tb/point_result_monitor.sv */
`timescale 1ns / 100ps

module point_result_monitor
    import bcpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    bcpa_in_if          in_ch,
    bcpa_out_if         out_ch,
    output int          mismatches,
    output int          outstanding
);

    // y is carried at full word width between steps of a scalar multiplication
    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
    } curve_point_t;

    logic [5:0]   field_degree;
    logic [63:0]  modulus;
    logic [62:0]  curve_a2;
    curve_point_t expected_points[$];

    function automatic int degree_in_use();
        if (field_degree < DEG_MIN)
        begin
            return DEG_MIN;
        end
        if (field_degree > DEG_MAX)
        begin
            return DEG_MAX;
        end
        return field_degree;
    endfunction

    function automatic int msb_pos(input logic [63:0] v);
        int d;
        d = -1;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                d = i;
            end
        end
        return d;
    endfunction

    function automatic logic [63:0] gf_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        logic [63:0] hi;
        r  = '0;
        hi = 64'd1 << degree_in_use();
        while (b != 0)
        begin
            if (b[0])
            begin
                r ^= a;
            end
            b = b >> 1;
            a = a << 1;
            if ((a & hi) != 0)
            begin
                a ^= modulus;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] gf_inv(input logic [63:0] a);
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] g1;
        logic [63:0] g2;
        logic [63:0] t;
        int          j;
        int          guard;
        u     = a;
        v     = modulus;
        g1    = 64'd1;
        g2    = '0;
        guard = 0;
        if (a == 0)
        begin
            return '0;
        end
        while (u != 64'd1)
        begin
            if (u == 0 || v == 0 || guard > GUARD_MAX)
            begin
                return '0;
            end
            guard++;
            j = msb_pos(u) - msb_pos(v);
            if (j < 0)
            begin
                t  = u;
                u  = v;
                v  = t;
                t  = g1;
                g1 = g2;
                g2 = t;
                j  = -j;
            end
            u  ^= v << j;
            g1 ^= g2 << j;
        end
        return g1;
    endfunction

    function automatic curve_point_t point_sum(input curve_point_t p, input curve_point_t q);
        curve_point_t r;
        logic [63:0]  lam;
        logic [63:0]  x3;
        logic [63:0]  ry;
        if (p.x == INF_X)
        begin
            return q;
        end
        if (q.x == INF_X)
        begin
            return p;
        end
        if (p.x == q.x)
        begin
            if (p.y != q.y || p.x == 0)
            begin
                r.x = INF_X;
                r.y = '0;
                return r;
            end
            lam = p.x ^ gf_mul(p.y, gf_inv(p.x));
            x3  = gf_mul(lam, lam) ^ lam ^ {1'b0, curve_a2};
            ry  = gf_mul(p.x, p.x) ^ gf_mul(lam ^ 64'd1, x3);
        end
        else
        begin
            lam = gf_mul(p.y ^ q.y, gf_inv(p.x ^ q.x));
            x3  = gf_mul(lam, lam) ^ lam ^ p.x ^ q.x ^ {1'b0, curve_a2};
            ry  = gf_mul(lam, p.x ^ x3) ^ x3 ^ p.y;
        end
        r.x = x3;
        r.y = ry;
        return r;
    endfunction

    function automatic curve_point_t predict_point(input logic mode, input curve_point_t p,
                                                   input curve_point_t q,
                                                   input logic [63:0] k);
        curve_point_t acc;
        if (mode == 1'b0)
        begin
            acc = point_sum(p, q);
        end
        else
        begin
            acc.x = INF_X;
            acc.y = '0;
            for (int i = 63; i >= 0; i--)
            begin
                acc = point_sum(acc, acc);
                if (k[i])
                begin
                    acc = point_sum(acc, p);
                end
            end
        end
        if (acc.x == INF_X)
        begin
            acc.y = '0;
        end
        acc.y[63] = 1'b0;
        return acc;
    endfunction

    assign outstanding = expected_points.size();

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t p;
        curve_point_t q;
        curve_point_t got;
        curve_point_t want;
        if (!rst_n)
        begin
            field_degree <= 6'd2;
            modulus      <= 64'd7;
            curve_a2     <= '0;
            mismatches   <= 0;
            expected_points.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_FIELD_DEGREE: field_degree <= cfg_data[5:0];
                    CFG_MODULUS:      modulus      <= cfg_data;
                    CFG_CURVE_A2:     curve_a2     <= cfg_data[62:0];
                    default:          ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                p.x = in_ch.first_x;
                p.y = {1'b0, in_ch.first_y};
                q.x = in_ch.second_x;
                q.y = {1'b0, in_ch.second_y};
                expected_points.push_back(predict_point(in_ch.mode, p, q, in_ch.scalar));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.x = out_ch.result_x;
                got.y = {1'b0, out_ch.result_y};
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result transaction x %h y %h", got.x, got.y);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x)
                    begin
                        $error("result_x mismatch: expected %h, actual %h", want.x, got.x);
                    end
                    if (got.y !== want.y)
                    begin
                        $error("result_y mismatch: expected %h, actual %h", want.y, got.y);
                    end
                    if (got.x !== want.x || got.y !== want.y)
                    begin
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/binary_curve_point_arithmetic_top_test.sv */
`timescale 1ns / 100ps

module binary_curve_point_arithmetic_top_test;
    import bcpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    int          mismatches;
    int          outstanding;
    int          sent;
    int          received;
    int          settings;
    int          cur_degree;
    int          big_left;

    bcpa_in_if  in_ch();
    bcpa_out_if out_ch();

    binary_curve_point_arithmetic_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    point_result_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #1000ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int draw_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] field_elem();
        return rand_word() & ((64'd1 << cur_degree) - 64'd1);
    endfunction

    task automatic send_point_op(input logic mode, input logic [63:0] x1, input logic [63:0] y1,
                                 input logic [63:0] x2, input logic [63:0] y2,
                                 input logic [63:0] k);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= mode;
        in_ch.first_x  <= x1;
        in_ch.first_y  <= y1[62:0];
        in_ch.second_x <= x2;
        in_ch.second_y <= y2[62:0];
        in_ch.scalar   <= k;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_curve(input int deg, input logic [63:0] poly, input logic [62:0] a2);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        write_reg(CFG_FIELD_DEGREE, 64'(deg));
        write_reg(CFG_MODULUS, poly);
        write_reg(CFG_CURVE_A2, {1'b0, a2});
        cur_degree = (deg < DEG_MIN) ? DEG_MIN : deg;
        settings++;
    endtask

    task automatic random_ops(input int count);
        int          pick;
        logic [63:0] x1;
        logic [63:0] y1;
        logic [63:0] x2;
        logic [63:0] y2;
        logic [63:0] k;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            x1   = field_elem();
            y1   = field_elem();
            x2   = field_elem();
            y2   = field_elem();
            k    = rand_word();
            if (pick < 15)
            begin
                send_point_op($urandom_range(0, 1), rand_word(), rand_word(), rand_word(),
                              rand_word(), 64'($urandom_range(0, 63)));
            end
            else if (pick < 25)
            begin
                send_point_op(1'b0, x1, y1, x1, y1, k);
            end
            else if (pick < 32)
            begin
                send_point_op(1'b0, x1, y1, x1, x1 ^ y1, k);
            end
            else if (pick < 36)
            begin
                send_point_op(1'b0, INF_X, y1, x2, y2, k);
            end
            else if (pick < 65)
            begin
                send_point_op(1'b0, x1, y1, x2, y2, k);
            end
            else if (pick < 68 && big_left > 0)
            begin
                big_left--;
                send_point_op(1'b1, x1, y1, x2, y2, k);
            end
            else
            begin
                send_point_op(1'b1, x1, y1, x2, y2, 64'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic directed_ops();
        logic [63:0] px;
        logic [63:0] py;
        px = 64'h53;
        py = 64'hca;
        send_point_op(1'b0, INF_X, 64'h1, px, py, '0);
        send_point_op(1'b0, px, py, INF_X, 64'h7fff_ffff_ffff_ffff, '0);
        send_point_op(1'b0, INF_X, 64'h7fff_ffff_ffff_ffff, INF_X, 64'h5, '1);
        send_point_op(1'b0, px, py, px, py, '0);
        send_point_op(1'b0, '0, py, '0, py, '0);
        send_point_op(1'b0, px, py, px, px ^ py, '0);
        send_point_op(1'b0, px, py, 64'h11, 64'h2a, '0);
        send_point_op(1'b0, '0, '0, 64'h1, 64'h1, '0);
        send_point_op(1'b0, 64'hffff_ffff_ffff_fffe, 64'h7fff_ffff_ffff_ffff,
                      64'h1234_5678_9abc_def0, 64'h7edc_ba98_7654_3210, '0);
        send_point_op(1'b1, px, py, 64'h11, 64'h2a, '0);
        send_point_op(1'b1, px, py, INF_X, '0, 64'd1);
        send_point_op(1'b1, px, py, '0, '0, 64'd2);
        send_point_op(1'b1, px, py, '0, '0, 64'd13);
        send_point_op(1'b1, INF_X, py, '0, '0, 64'd7);
        send_point_op(1'b1, '0, py, '0, '0, 64'd5);
        send_point_op(1'b1, px, py, '1, '1, '1);
    endtask

    initial
    begin
        int hold;
        received = 0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (received == 5)
            begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            hold = draw_gap();
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            received++;
        end
    end

    initial
    begin
        int waited;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_FIELD_DEGREE;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.mode     <= 1'b0;
        in_ch.first_x  <= '0;
        in_ch.first_y  <= '0;
        in_ch.second_x <= '0;
        in_ch.second_y <= '0;
        in_ch.scalar   <= '0;
        sent       = 0;
        settings   = 1;
        cur_degree = 2;
        big_left   = 3;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        random_ops(12);
        set_curve(8, 64'h11b, 63'h1);
        directed_ops();
        random_ops(12);
        set_curve(63, 64'h8000_0000_0000_0003, 63'(rand_word()));
        random_ops(18);
        set_curve(0, 64'h7, 63'h7fff_ffff_ffff_ffff);
        random_ops(12);
        set_curve(17, 64'h2_0009, '0);
        random_ops(18);
        set_curve(63, '1, '0);
        random_ops(12);

        in_ch.valid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < 500000)
        begin
            @(posedge clk);
            waited++;
        end
        if (outstanding != 0)
        begin
            $display("Mismatches found");
            $finish;
        end
        repeat (200) @(posedge clk);
        $display("covered %0d transactions over %0d curve settings, additions and", sent,
                 settings);
        $display("scalar multiplications with infinity, doubling and inverse operands");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
